FILE: rtl/core/tgarle_pkg.sv
// Shared types and constants for the Targa RLE pixel decoder.
// No dependencies; every other file of the block refers to this package.
package tgarle_pkg;

	// Default buffer limits
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	// Field widths
	localparam int BYTE_W     = 8;
	localparam int ADDR_W     = 16;
	localparam int COLOR_W    = 32;
	localparam int LEN_W      = 8;
	localparam int OUT_DATA_W = 56;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;
	localparam int DIM_W      = 9;

	// Input word kinds carried on tuser
	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_PRESENT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RLE_MODE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_FLIP      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd4;

	// Register reset values
	localparam logic             RST_ALPHA_PRESENT = 1'b0;
	localparam logic             RST_RLE_MODE      = 1'b1;
	localparam logic             RST_ROW_FLIP      = 1'b1;
	localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH   = 9'd16;
	localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT  = 9'd11;

	// Packet header layout and pixel constants
	localparam int                RUN_FLAG_BIT = 7;
	localparam logic [6:0]        COUNT_MASK   = 7'h7f;
	localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hff;
	localparam int                MIN_WIDTH    = 4;
	localparam int                MIN_HEIGHT   = 1;

	typedef struct packed {
		logic             alpha_present;
		logic             rle_mode;
		logic             row_flip;
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic clear;
		logic hdr;
		logic gather;
		logic settle;
		logic base;
		logic emit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic want_hdr;
		logic finished;
		logic pix_done;
		logic settle_fin;
		logic emit_last;
		logic out_free;
	} stat_t;

endpackage

FILE: rtl/core/tgarle_cfg_regs.sv
// Configuration register file of the Targa RLE pixel decoder.
// Depends on tgarle_pkg for register indexes, reset values and cfg_t.
module tgarle_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_open,
	output logic                                cfg_ready,
	input  logic [tgarle_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tgarle_pkg::CFG_DATA_W-1:0]   cfg_data,
	output tgarle_pkg::cfg_t                    cfg
);

	tgarle_pkg::cfg_t cfg_q;
	logic             wr;

	assign cfg_ready = cfg_open;
	assign wr        = cfg_valid && cfg_open;
	assign cfg       = cfg_q;

	// Register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha_present <= tgarle_pkg::RST_ALPHA_PRESENT;
			cfg_q.rle_mode      <= tgarle_pkg::RST_RLE_MODE;
			cfg_q.row_flip      <= tgarle_pkg::RST_ROW_FLIP;
			cfg_q.image_width   <= tgarle_pkg::RST_IMAGE_WIDTH;
			cfg_q.image_height  <= tgarle_pkg::RST_IMAGE_HEIGHT;
		end else if (wr) begin
			unique case (cfg_index)
				tgarle_pkg::REG_ALPHA_PRESENT: cfg_q.alpha_present <= cfg_data[0];
				tgarle_pkg::REG_RLE_MODE:      cfg_q.rle_mode      <= cfg_data[0];
				tgarle_pkg::REG_ROW_FLIP:      cfg_q.row_flip      <= cfg_data[0];
				tgarle_pkg::REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data;
				tgarle_pkg::REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/core/tgarle_datapath.sv
// Datapath of the Targa RLE pixel decoder: pixel gather, packet state,
// position, row base multiplier and output register. Depends on tgarle_pkg.
module tgarle_datapath #(
	parameter int MAX_WIDTH  = tgarle_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = tgarle_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tgarle_pkg::cfg_t                    cfg,
	input  tgarle_pkg::cmd_t                    cmd,
	output tgarle_pkg::stat_t                   stat,
	input  logic [tgarle_pkg::BYTE_W-1:0]       byte_in,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tgarle_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                                m_tlast,
	output logic [0:0]                          m_tuser
);

	localparam int CW   = $clog2(MAX_WIDTH + 1);
	localparam int RW   = $clog2(MAX_HEIGHT + 1);
	localparam int PW   = CW + RW;
	localparam int CLW  = (CW > tgarle_pkg::DIM_W) ? CW : tgarle_pkg::DIM_W;
	localparam int RLW  = (RW > tgarle_pkg::DIM_W) ? RW : tgarle_pkg::DIM_W;
	localparam int CMPW = (CW > tgarle_pkg::LEN_W) ? CW : tgarle_pkg::LEN_W;

	localparam int AW = tgarle_pkg::ADDR_W;
	localparam int LW = tgarle_pkg::LEN_W;

	// Decode state
	logic [1:0]                        phase_q;
	logic [tgarle_pkg::COLOR_W-1:0]    color_q;
	logic [LW-1:0]                     rem_q;
	logic                              is_run_q;
	logic                              expect_q;
	logic [CW-1:0]                     col_q;
	logic [RW-1:0]                     row_q;
	logic                              fin_q;
	logic [AW-1:0]                     base_q;
	logic [LW-1:0]                     cnt_q;

	// Output register
	logic                              out_valid_q;
	logic [AW-1:0]                     out_addr_q;
	logic [tgarle_pkg::COLOR_W-1:0]    out_color_q;
	logic [LW-1:0]                     out_len_q;
	logic                              out_last_q;
	logic                              out_done_q;

	// Combinational helpers
	logic [CLW-1:0]                    w_wide;
	logic [RLW-1:0]                    h_wide;
	logic [CW-1:0]                     w_eff;
	logic [RW-1:0]                     h_eff;
	logic [tgarle_pkg::COLOR_W-1:0]    color_ins;
	logic [tgarle_pkg::COLOR_W-1:0]    color_px;
	logic                              complete;
	logic [LW-1:0]                     rem_norm;
	logic [LW-1:0]                     rem_after;
	logic                              wrap;
	logic [RW:0]                       row_inc;
	logic [RW:0]                       row_t;
	logic                              settle_fin;
	logic [RW-1:0]                     row_sel;
	logic [PW-1:0]                     prod;
	logic [CW-1:0]                     wr_left;
	logic                              take;
	logic [LW-1:0]                     n_fill;
	logic [LW-1:0]                     cnt_next;
	logic                              emit_fin;
	logic                              emit_last;
	logic                              out_free;

	// Clamp the configured dimensions to the supported range
	always_comb begin
		w_wide = CLW'(cfg.image_width);
		if (w_wide < CLW'(tgarle_pkg::MIN_WIDTH))
			w_wide = CLW'(tgarle_pkg::MIN_WIDTH);
		else if (w_wide > CLW'(MAX_WIDTH))
			w_wide = CLW'(MAX_WIDTH);
		h_wide = RLW'(cfg.image_height);
		if (h_wide < RLW'(tgarle_pkg::MIN_HEIGHT))
			h_wide = RLW'(tgarle_pkg::MIN_HEIGHT);
		else if (h_wide > RLW'(MAX_HEIGHT))
			h_wide = RLW'(MAX_HEIGHT);
	end
	assign w_eff = CW'(w_wide);
	assign h_eff = RW'(h_wide);

	// Drop the incoming byte into its colour lane
	always_comb begin
		color_ins = color_q;
		for (int i = 0; i < 4; i++) begin
			if (phase_q == 2'(i))
				color_ins[8*i +: 8] = byte_in;
		end
	end

	// Pixel ends on the red byte without alpha, on the alpha byte otherwise
	assign complete = (phase_q == 2'd3) || ((phase_q == 2'd2) && !cfg.alpha_present);
	assign color_px = (phase_q == 2'd2) ? {tgarle_pkg::ALPHA_OPAQUE, color_ins[23:0]}
	                                    : color_ins;

	// Packet count after this pixel
	assign rem_norm  = (rem_q == '0) ? LW'(1) : rem_q;
	assign rem_after = is_run_q ? '0 : rem_norm - LW'(1);

	// Row wrap and end of image for the pre-fill settle
	assign wrap       = (col_q >= w_eff);
	assign row_inc    = {1'b0, row_q} + (RW+1)'(1);
	assign row_t      = wrap ? row_inc : {1'b0, row_q};
	assign settle_fin = (row_t >= {1'b0, h_eff});

	// Row base: buffer row times width
	assign row_sel = cfg.row_flip ? (h_eff - RW'(1) - row_q) : row_q;
	assign prod    = PW'(row_sel) * PW'(w_eff);

	// One fill piece, cut at the row end
	assign wr_left   = w_eff - col_q;
	assign take      = (CMPW'(cnt_q) >= CMPW'(wr_left));
	assign n_fill    = take ? LW'(wr_left) : cnt_q;
	assign cnt_next  = cnt_q - n_fill;
	assign emit_fin  = take && (row_inc >= {1'b0, h_eff});
	assign emit_last = (cnt_next == '0) || emit_fin;
	assign out_free  = !out_valid_q || m_tready;

	assign stat.want_hdr   = cfg.rle_mode && expect_q;
	assign stat.finished   = fin_q;
	assign stat.pix_done   = complete;
	assign stat.settle_fin = settle_fin;
	assign stat.emit_last  = emit_last;
	assign stat.out_free   = out_free;

	// Decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			color_q  <= '0;
			rem_q    <= '0;
			is_run_q <= 1'b0;
			expect_q <= 1'b1;
			col_q    <= '0;
			row_q    <= '0;
			fin_q    <= 1'b0;
			base_q   <= '0;
			cnt_q    <= '0;
		end else begin
			if (cmd.clear) begin
				phase_q  <= '0;
				color_q  <= '0;
				rem_q    <= '0;
				is_run_q <= 1'b0;
				expect_q <= 1'b1;
				col_q    <= '0;
				row_q    <= '0;
				fin_q    <= 1'b0;
			end
			if (cmd.hdr) begin
				is_run_q <= byte_in[tgarle_pkg::RUN_FLAG_BIT];
				rem_q    <= LW'(byte_in[6:0] & tgarle_pkg::COUNT_MASK) + LW'(1);
				expect_q <= 1'b0;
				phase_q  <= '0;
			end
			if (cmd.gather) begin
				if (complete) begin
					phase_q <= '0;
					color_q <= color_px;
					if (cfg.rle_mode) begin
						cnt_q <= is_run_q ? rem_norm : LW'(1);
						rem_q <= rem_after;
						if (rem_after == '0)
							expect_q <= 1'b1;
					end else begin
						cnt_q <= LW'(1);
					end
				end else begin
					phase_q <= phase_q + 2'd1;
					color_q <= color_ins;
				end
			end
			if (cmd.settle) begin
				if (wrap)
					col_q <= '0;
				row_q <= RW'(row_t);
				if (settle_fin) begin
					fin_q <= 1'b1;
					if (cfg.rle_mode) begin
						rem_q    <= '0;
						expect_q <= 1'b1;
					end
				end
			end
			if (cmd.base)
				base_q <= AW'(prod);
			if (cmd.emit) begin
				cnt_q <= cnt_next;
				if (take) begin
					col_q <= '0;
					row_q <= RW'(row_inc);
				end else begin
					col_q <= col_q + CW'(n_fill);
				end
				if (emit_fin) begin
					fin_q <= 1'b1;
					if (cfg.rle_mode) begin
						rem_q    <= '0;
						expect_q <= 1'b1;
					end
				end
			end
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_addr_q  <= base_q + AW'(col_q);
			out_color_q <= color_q;
			out_len_q   <= n_fill;
			out_last_q  <= emit_last;
			out_done_q  <= emit_fin;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_len_q, out_color_q, out_addr_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_done_q;

`ifndef ASSERT_OFF
	// A new word never overwrites one still waiting
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || m_tready))
		else $error("fill word issued with output register occupied");

	// Every fill piece covers at least one pixel
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (out_len_q != '0))
		else $error("zero length fill piece");

	// End of image is only reached by a settle or a fill
	a_fin_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fin_q) |-> $past(cmd.settle || cmd.emit))
		else $error("image finished without a position update");

	// The word that finishes the image closes its byte's results
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_done_q) |-> out_last_q)
		else $error("image done flagged on a word that is not last");
`endif

endmodule

FILE: rtl/core/tgarle_ctrl.sv
// Controller of the Targa RLE pixel decoder: byte acceptance and fill
// sequencing. Depends on tgarle_pkg for cmd_t, stat_t and the op codes.
module tgarle_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic                 op,
	input  tgarle_pkg::stat_t    stat,
	output tgarle_pkg::cmd_t     cmd,
	output logic                 idle
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SETTLE = 2'd1;
	localparam logic [1:0] S_BASE   = 2'd2;
	localparam logic [1:0] S_EMIT   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign idle     = (state_q == S_IDLE);
	assign s_tready = idle;
	assign accept   = s_tvalid && s_tready;

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (op == tgarle_pkg::OP_START) begin
						cmd.clear = 1'b1;
					end else if (!stat.finished) begin
						if (stat.want_hdr) begin
							cmd.hdr = 1'b1;
						end else begin
							cmd.gather = 1'b1;
							if (stat.pix_done)
								state_d = S_SETTLE;
						end
					end
				end
			end
			S_SETTLE: begin
				cmd.settle = 1'b1;
				state_d    = stat.settle_fin ? S_IDLE : S_BASE;
			end
			S_BASE: begin
				cmd.base = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = stat.emit_last ? S_IDLE : S_BASE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

`ifndef ASSERT_OFF
	// A start word leaves the decoder ready for the next word
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op == tgarle_pkg::OP_START)) |=> (state_q == S_IDLE))
		else $error("start word did not return to idle");

	// A fill waits in place while the output register is full
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_EMIT) && !stat.out_free) |=> (state_q == S_EMIT))
		else $error("fill abandoned while output stalled");
`endif

endmodule

FILE: rtl/core/tga_rle_pixel_decoder_core.sv
// Top level of the Targa RLE pixel decoder.
// Depends on tgarle_pkg, tgarle_cfg_regs, tgarle_datapath and tgarle_ctrl.

// Takes Targa pixel data one byte per word after the file header and turns it
// into fill words of buffer address, ARGB colour and run length. A word with
// tuser low starts a new image. A byte that finishes a pixel first settles the
// row position, then for each fill word passes the row base multiplier state
// and then the output register load state; a stalled master side holds the
// sequence in its load state. Runs that reach a row end are split there, so a
// run gives up to 33 words. The input side and the configuration port are
// ready only between bytes; an output word may still be waiting while the
// next byte is taken.
module tga_rle_pixel_decoder_core #(
	parameter int MAX_WIDTH  = tgarle_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = tgarle_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tgarle_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] data_byte
	input  logic [0:0]                          s_tuser,   // [0] op
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tgarle_pkg::OUT_DATA_W-1:0]   m_tdata,   // [15:0] pixel_address,
	                                                        // [47:16] pixel_color,
	                                                        // [55:48] run_length
	output logic                                m_tlast,   // last_of_run
	output logic [0:0]                          m_tuser,   // [0] image_done
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tgarle_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tgarle_pkg::CFG_DATA_W-1:0]   cfg_data
);

	tgarle_pkg::cfg_t  cfg;
	tgarle_pkg::cmd_t  cmd;
	tgarle_pkg::stat_t stat;
	logic              idle;

	tgarle_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_open  (idle),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tgarle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser[0]),
		.stat     (stat),
		.cmd      (cmd),
		.idle     (idle)
	);

	tgarle_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.stat     (stat),
		.byte_in  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: dv/tb.sv
// Self-checking testbench for tga_rle_pixel_decoder_core.
// Depends on tgarle_pkg and the decoder RTL. Byte words go in through a queued driver,
// and a predictor inside the bench checks every fill word that comes out.
module tb;

	localparam int CLK_HALF       = 10;
	localparam int SETTLE_CYCLES  = 80;    // covers the fill sequence of the longest byte, plus margin
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int MAX_FILLS      = 33;
	localparam int MAX_ERR_SHOWN  = 10;
	localparam int PHASE_WORDS    = 40;
	localparam logic [tgarle_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic                          op;
		logic [tgarle_pkg::BYTE_W-1:0] data;
	} byte_word_t;

	typedef struct packed {
		logic [tgarle_pkg::ADDR_W-1:0]  pixel_address;
		logic [tgarle_pkg::COLOR_W-1:0] pixel_color;
		logic [tgarle_pkg::LEN_W-1:0]   run_length;
		logic                           last_of_run;
		logic                           image_done;
	} fill_word_t;

	logic                              clk       = 1'b0;
	logic                              arst_n    = 1'b0;
	logic                              s_tvalid  = 1'b0;
	logic                              s_tready;
	logic [tgarle_pkg::BYTE_W-1:0]     s_tdata   = '0;
	logic [0:0]                        s_tuser   = tgarle_pkg::OP_START;
	logic                              m_tvalid;
	logic                              m_tready  = 1'b0;
	logic [tgarle_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                              m_tlast;
	logic [0:0]                        m_tuser;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [tgarle_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [tgarle_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	// Stimulus and expectation stores
	byte_word_t stream_q [$];
	fill_word_t fill_q [$];
	byte_word_t next_word;
	int         n_queued    = 0;
	int         n_err       = 0;
	int         burst_left  = 0;
	int         gap_left    = 0;
	int         stall_left  = 0;
	int         stall_mode  = 0;
	int         beat        = 0;
	int         idle_cycles = 0;

	// Decoder mirror: register copies and walk state
	logic                           pred_alpha     = tgarle_pkg::RST_ALPHA_PRESENT;
	logic                           pred_rle       = tgarle_pkg::RST_RLE_MODE;
	logic                           pred_flip      = tgarle_pkg::RST_ROW_FLIP;
	logic [tgarle_pkg::DIM_W-1:0]   pred_width     = tgarle_pkg::RST_IMAGE_WIDTH;
	logic [tgarle_pkg::DIM_W-1:0]   pred_height    = tgarle_pkg::RST_IMAGE_HEIGHT;
	int                             pix_phase      = 0;
	logic [tgarle_pkg::COLOR_W-1:0] pix_gather     = '0;
	int                             pkt_left       = 0;
	logic                           pkt_is_run     = 1'b0;
	logic                           want_header    = 1'b1;
	int                             cur_col        = 0;
	int                             cur_row        = 0;
	logic [tgarle_pkg::ADDR_W-1:0]  cur_base       = '0;
	logic                           image_finished = 1'b0;

	tga_rle_pixel_decoder_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic int clamped_width();
		int w;
		w = int'(pred_width);
		if (w < tgarle_pkg::MIN_WIDTH) w = tgarle_pkg::MIN_WIDTH;
		if (w > tgarle_pkg::DEF_MAX_WIDTH) w = tgarle_pkg::DEF_MAX_WIDTH;
		return w;
	endfunction

	// Wrap the column into the next row, spot the end of the image, refresh the row base
	function automatic void advance_position();
		int w, h, base;
		w = clamped_width();
		h = int'(pred_height);
		if (h < tgarle_pkg::MIN_HEIGHT) h = tgarle_pkg::MIN_HEIGHT;
		if (h > tgarle_pkg::DEF_MAX_HEIGHT) h = tgarle_pkg::DEF_MAX_HEIGHT;
		if (cur_col >= w) begin
			cur_col = 0;
			cur_row++;
		end
		if (cur_row >= h) begin
			image_finished = 1'b1;
		end else begin
			base = pred_flip ? (h - 1 - cur_row) * w : cur_row * w;
			cur_base = base[tgarle_pkg::ADDR_W-1:0];
		end
	endfunction

	// Fill words for count pixels of one colour, split at every row end
	function automatic void predict_fills(logic [tgarle_pkg::COLOR_W-1:0] color, int count);
		fill_word_t word;
		logic       held;
		int         n, addr, k;
		held = 1'b0;
		word = '0;
		k = 0;
		while (count > 0 && k < MAX_FILLS && !image_finished) begin
			advance_position();
			if (!image_finished) begin
				n = clamped_width() - cur_col;
				if (n > count) n = count;
				addr = cur_base + cur_col;
				cur_col += n;
				count -= n;
				advance_position();
				if (held) fill_q.push_back(word);
				word.pixel_address = addr[tgarle_pkg::ADDR_W-1:0];
				word.pixel_color   = color;
				word.run_length    = n[tgarle_pkg::LEN_W-1:0];
				word.last_of_run   = 1'b0;
				word.image_done    = image_finished;
				held = 1'b1;
				k++;
			end
		end
		if (held) begin
			word.last_of_run = 1'b1;
			fill_q.push_back(word);
		end
	endfunction

	// Expected fill words for one accepted byte word
	function automatic void predict_byte(logic op, logic [tgarle_pkg::BYTE_W-1:0] b);
		int                             p;
		logic [tgarle_pkg::COLOR_W-1:0] color;
		if (op == tgarle_pkg::OP_START) begin
			pix_phase      = 0;
			pix_gather     = '0;
			pkt_left       = 0;
			pkt_is_run     = 1'b0;
			want_header    = 1'b1;
			cur_col        = 0;
			cur_row        = 0;
			cur_base       = '0;
			image_finished = 1'b0;
			advance_position();
		end else if (!image_finished) begin
			if (pred_rle && want_header) begin
				pkt_is_run  = b[tgarle_pkg::RUN_FLAG_BIT];
				pkt_left    = int'(b[6:0] & tgarle_pkg::COUNT_MASK) + 1;
				want_header = 1'b0;
				pix_phase   = 0;
			end else begin
				p = pix_phase;
				pix_gather[8*p +: 8] = b;
				if (p < 2 || (p == 2 && pred_alpha)) begin
					pix_phase = p + 1;
				end else begin
					pix_phase = 0;
					color = pix_gather;
					// 24-bit pixel: opaque alpha
					if (p == 2) color[31:24] = tgarle_pkg::ALPHA_OPAQUE;
					if (!pred_rle) begin
						predict_fills(color, 1);
					end else begin
						if (pkt_left == 0) pkt_left = 1;
						if (pkt_is_run) begin
							predict_fills(color, pkt_left);
							pkt_left = 0;
						end else begin
							predict_fills(color, 1);
							pkt_left--;
						end
						if (pkt_left == 0 || image_finished) begin
							pkt_left    = 0;
							want_header = 1'b1;
						end
					end
				end
			end
		end
	endfunction

	function automatic logic [tgarle_pkg::BYTE_W-1:0] rand_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_word(logic op, logic [tgarle_pkg::BYTE_W-1:0] b);
		byte_word_t w;
		w.op   = op;
		w.data = b;
		stream_q.push_back(w);
		n_queued++;
	endtask

	task automatic push_pixel();
		repeat (pred_alpha ? 4 : 3) push_word(tgarle_pkg::OP_DATA, rand_byte());
	endtask

	task automatic write_reg(logic [tgarle_pkg::CFG_IDX_W-1:0] idx,
			logic [tgarle_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Block idle: every byte taken, every fill word seen, then let the pipe run dry
	task automatic wait_idle();
		do @(negedge clk); while (stream_q.size() != 0 || s_tvalid || fill_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Byte driver: bursts of random length with random gaps
	always @(posedge clk) begin
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (gap_left != 0 || stream_q.size() == 0) begin
				s_tvalid <= 1'b0;
				if (gap_left != 0) gap_left <= gap_left - 1;
			end else begin
				next_word = stream_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= next_word.data;
				s_tuser  <= next_word.op;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 32);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Output back-pressure in randomly chosen modes
	always @(posedge clk) begin
		beat <= beat + 1;
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(8, 60);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= (beat % 3 == 0);
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Monitor: register writes, fill word checks, then prediction for the new byte
	always @(posedge clk) begin : monitor
		fill_word_t got;
		fill_word_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tgarle_pkg::REG_ALPHA_PRESENT: pred_alpha  = cfg_data[0];
					tgarle_pkg::REG_RLE_MODE:      pred_rle    = cfg_data[0];
					tgarle_pkg::REG_ROW_FLIP:      pred_flip   = cfg_data[0];
					tgarle_pkg::REG_IMAGE_WIDTH:   pred_width  = cfg_data;
					tgarle_pkg::REG_IMAGE_HEIGHT:  pred_height = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.pixel_address = m_tdata[15:0];
				got.pixel_color   = m_tdata[47:16];
				got.run_length    = m_tdata[55:48];
				got.last_of_run   = m_tlast;
				got.image_done    = m_tuser[0];
				if (fill_q.size() == 0) begin
					if (n_err < MAX_ERR_SHOWN)
						$display({"unexpected fill word: addr %h colour %h len %0d",
							" last %b done %b"},
							got.pixel_address, got.pixel_color, got.run_length,
							got.last_of_run, got.image_done);
					n_err++;
				end else begin
					want = fill_q.pop_front();
					if (got !== want) begin
						if (n_err < MAX_ERR_SHOWN) begin
							$display({"fill word mismatch: expected addr %h colour %h",
								" len %0d last %b done %b"},
								want.pixel_address, want.pixel_color, want.run_length,
								want.last_of_run, want.image_done);
							$display({"                    got      addr %h colour %h",
								" len %0d last %b done %b"},
								got.pixel_address, got.pixel_color, got.run_length,
								got.last_of_run, got.image_done);
						end
						n_err++;
					end
				end
			end
			if (s_tvalid && s_tready) predict_byte(s_tuser[0], s_tdata);
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [tgarle_pkg::BYTE_W-1:0] opening [21];
		logic [tgarle_pkg::DIM_W-1:0]  widths [10];
		logic [tgarle_pkg::DIM_W-1:0]  heights [10];
		logic [tgarle_pkg::BYTE_W-1:0] header;
		logic                          is_run;
		int                            goal, count;

		// Right after reset, default registers (16 x 11, run-length, flipped):
		// full-length run over eight rows, two raw pixels of extreme colour, single-pixel run,
		// then a long run that overshoots the last pixel and two bytes that must be ignored
		opening = '{8'hff, 8'h00, 8'hff, 8'h5a,
			8'h01, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00,
			8'h80, 8'ha5, 8'h5a, 8'h3c,
			8'hff, 8'h12, 8'h34, 8'h56,
			8'h7e, 8'h81};
		widths  = '{9'd4, 9'd256, 9'd3, 9'd511, 9'd5, 9'd9, 9'd0, 9'd300, 9'd6, 9'd17};
		heights = '{9'd1, 9'd256, 9'd256, 9'd0, 9'd511, 9'd3, 9'd5, 9'd1, 9'd4, 9'd2};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (opening[i]) push_word(tgarle_pkg::OP_DATA, opening[i]);
		push_word(tgarle_pkg::OP_START, 8'haa);
		push_word(tgarle_pkg::OP_DATA, 8'h00);
		push_word(tgarle_pkg::OP_DATA, 8'h3c);
		push_word(tgarle_pkg::OP_DATA, 8'hc3);
		push_word(tgarle_pkg::OP_DATA, 8'h96);
		push_word(tgarle_pkg::OP_START, 8'h00);    // start while the image is under way

		// Settings changed part way through an image
		wait_idle();
		write_reg(tgarle_pkg::REG_ALPHA_PRESENT, {rand_byte(), 1'b1});
		write_reg(tgarle_pkg::REG_ROW_FLIP, {rand_byte(), 1'b0});
		write_reg(tgarle_pkg::REG_IMAGE_WIDTH, 9'd8);
		write_reg(tgarle_pkg::REG_IMAGE_HEIGHT, 9'd2);
		push_word(tgarle_pkg::OP_START, 8'h00);
		push_word(tgarle_pkg::OP_DATA, 8'h85);
		push_word(tgarle_pkg::OP_DATA, 8'h11);
		push_word(tgarle_pkg::OP_DATA, 8'h22);
		push_word(tgarle_pkg::OP_DATA, 8'h33);
		wait_idle();
		// alpha dropped after the red byte: the next byte fills the alpha lane
		write_reg(tgarle_pkg::REG_ALPHA_PRESENT, {rand_byte(), 1'b0});
		push_word(tgarle_pkg::OP_DATA, 8'h44);
		wait_idle();
		// rows narrowed below the current column: the row ends at once
		write_reg(tgarle_pkg::REG_IMAGE_WIDTH, 9'd4);
		push_word(tgarle_pkg::OP_DATA, 8'h83);
		push_word(tgarle_pkg::OP_DATA, 8'ha0);
		push_word(tgarle_pkg::OP_DATA, 8'hb0);
		push_word(tgarle_pkg::OP_DATA, 8'hc0);
		push_word(tgarle_pkg::OP_DATA, 8'h5a);
		wait_idle();
		write_reg(REG_UNUSED, 9'h1ff);

		// Random images, one setting per phase, extremes and clamped sizes included
		for (int ph = 0; ph < 10; ph++) begin
			wait_idle();
			write_reg(tgarle_pkg::REG_ALPHA_PRESENT, {rand_byte(), ph[0]});
			write_reg(tgarle_pkg::REG_RLE_MODE, {rand_byte(), ph % 4 != 2});
			write_reg(tgarle_pkg::REG_ROW_FLIP, {rand_byte(), ph % 3 != 0});
			write_reg(tgarle_pkg::REG_IMAGE_WIDTH, widths[ph]);
			write_reg(tgarle_pkg::REG_IMAGE_HEIGHT, heights[ph]);
			goal = n_queued + PHASE_WORDS;
			push_word(tgarle_pkg::OP_START, rand_byte());
			while (n_queued < goal) begin
				case ($urandom_range(0, 15))
					// stray byte, stream falls out of step
					0: push_word(tgarle_pkg::OP_DATA, rand_byte());
					// new image, often mid packet
					1: push_word(tgarle_pkg::OP_START, rand_byte());
					default: begin
						if (!pred_rle) begin
							push_pixel();
						end else begin
							is_run = 1'($urandom_range(0, 1));
							case ($urandom_range(0, 9))
								0: count = $urandom_range(100, 128);
								1, 2: count = $urandom_range(7, 40);
								default: count = $urandom_range(1, 6);
							endcase
							// raw packets kept short to save bytes
							if (!is_run && count > 4) count = $urandom_range(1, 4);
							header = 8'(count - 1);
							header[tgarle_pkg::RUN_FLAG_BIT] = is_run;
							push_word(tgarle_pkg::OP_DATA, header);
							repeat (is_run ? 1 : count) push_pixel();
						end
					end
				endcase
			end
		end

		wait_idle();
		if (n_err == 0 && fill_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
